[rtl/core/sha256_stream_hasher_assert.svh]
// Assertion macros for the SHA-256 stream hasher
// The asserting module provides i_clk and i_rst_n.
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH
// implication checked every clock outside reset
`define SHA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication checked every clock outside reset
`define SHA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[rtl/core/sha256_pkg.sv]
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and round functions for the SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // datapath commands
    typedef struct packed {
        logic       wr_byte;     // store byte into buffer at fill pointer
        logic       wr_pad80;    // store 0x80 at fill pointer
        logic       wr_zero;     // store zero at fill pointer
        logic       wr_len;      // store length byte at fill pointer
        logic       clr_head;    // meant to restart fill pointer at byte 0; never set, and ignored by the datapath
        logic       ptr_inc;     // advance fill pointer
        logic       comp_start;  // load working words from hash
        logic       round_en;    // run one round
        logic       comp_done;   // fold working words into hash
        logic       add_block;   // count 512 bits
        logic       latch_total; // snapshot bit length for padding
        logic       restart;     // back to initial hash
    } t_cmd;

    typedef struct packed {
        logic [5:0] fill;        // fill pointer
        logic [5:0] round;       // current round
    } t_stat;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

[rtl/core/sha256_ctrl.sv]
// ----------------------------------------------------------------------------
// sha256_ctrl
// Sequencer: byte intake, padding, 64-round compression and digest output.
// ----------------------------------------------------------------------------
module sha256_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_op,
    input  logic                 i_out_ready,
    input  sha256_pkg::t_stat    i_stat,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    output logic [2:0]           o_out_idx,
    output sha256_pkg::t_cmd     o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_ROUND, S_FOLD, S_PAD, S_LEN, S_EMIT
    } t_state;

    t_state     r_state, n_state;
    logic       r_final, n_final;   // compression is the last block of the finish
    logic       r_pend, n_pend;     // a finish is under way
    logic [2:0] r_idx, n_idx;
    logic       w_acc;
    logic       w_last_round;

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = (r_state == S_EMIT);
    assign o_out_idx    = r_idx;
    assign w_acc        = i_in_valid && o_in_ready;
    assign w_last_round = (r_state == S_ROUND) && (i_stat.round == 6'd63);

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_final = r_final;
        n_idx   = r_idx;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (i_in_op == sha256_pkg::OP_ABSORB) begin
                        o_cmd.wr_byte = 1'b1;
                        o_cmd.ptr_inc = 1'b1;
                        if (i_stat.fill == 6'd63) begin
                            o_cmd.comp_start = 1'b1;
                            o_cmd.add_block  = 1'b1;
                            n_final = 1'b0;
                            n_state = S_ROUND;
                        end
                    end else begin
                        o_cmd.latch_total = 1'b1;
                        o_cmd.wr_pad80    = 1'b1;
                        o_cmd.ptr_inc     = 1'b1;
                        if (i_stat.fill == 6'd63) begin
                            o_cmd.comp_start = 1'b1;
                            n_final = 1'b0;
                            n_state = S_ROUND;
                        end else begin
                            n_state = S_PAD;
                        end
                    end
                end
            end
            S_ROUND: begin
                o_cmd.round_en = 1'b1;
                if (i_stat.round == 6'd63) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                o_cmd.comp_done = 1'b1;
                if (r_final) begin
                    n_idx   = 3'd0;
                    n_state = S_EMIT;
                end else if (r_pend) begin
                    // padding continues if a finish is under way
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_PAD: begin
                // zero up to byte 56, wrapping through a block if needed
                if (i_stat.fill == 6'd56) begin
                    n_state = S_LEN;
                end else begin
                    o_cmd.wr_zero = 1'b1;
                    o_cmd.ptr_inc = 1'b1;
                    if (i_stat.fill == 6'd63) begin
                        o_cmd.comp_start = 1'b1;
                        n_final = 1'b0;
                        n_state = S_ROUND;
                    end
                end
            end
            S_LEN: begin
                o_cmd.wr_len  = 1'b1;
                o_cmd.ptr_inc = 1'b1;
                if (i_stat.fill == 6'd63) begin
                    o_cmd.comp_start = 1'b1;
                    n_final = 1'b1;
                    n_state = S_ROUND;
                end
            end
            S_EMIT: begin
                if (i_out_ready) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        o_cmd.restart = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // finish tracking, held across an early padding block
    always_comb begin
        n_pend = r_pend;
        if (w_acc && i_in_op == sha256_pkg::OP_FINISH) n_pend = 1'b1;
        if (o_cmd.restart) n_pend = 1'b0;
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_final <= 1'b0;
            r_idx   <= 3'd0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_final <= n_final;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
        end
    end

    `include "sha256_stream_hasher_assert.svh"
    `SHA_ASSERT_IMP(a_ready_idle, o_in_ready, !o_out_valid, "ready while emitting")
    `SHA_ASSERT_NEXT(a_fold_after_round, w_last_round, r_state == S_FOLD, "missing fold")
    `SHA_ASSERT_IMP(a_emit_final, r_state == S_EMIT, r_pend, "emit outside finish")

endmodule

[rtl/core/sha256_dpath.sv]
// ----------------------------------------------------------------------------
// sha256_dpath
// Block buffer, message schedule, round unit, hash state and bit counter.
// ----------------------------------------------------------------------------
module sha256_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [7:0]         i_byte,
    input  logic [2:0]         i_out_idx,
    input  sha256_pkg::t_cmd   i_cmd,
    output sha256_pkg::t_stat  o_stat,
    output logic [31:0]        o_digest
);

    logic [31:0] r_buf [16];     // block buffer, big-endian words
    logic [31:0] r_w [16];
    logic [31:0] r_wnext;        // schedule word of the next round
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [5:0]  r_fill;
    logic [5:0]  r_round;
    logic [63:0] r_bits;
    logic [63:0] r_total;

    logic [7:0]  w_wbyte;
    logic [31:0] w_sched, w_w2, w_w15, w_s0, w_s1, w_t1, w_t2, w_e, w_a, w_ch, w_maj;
    logic [63:0] w_tot;
    logic [2:0]  w_lsel;

    // byte written into the buffer
    assign w_lsel = r_fill[2:0];
    assign w_tot  = r_bits + {55'd0, r_fill, 3'd0};
    always_comb begin
        w_wbyte = i_byte;
        if (i_cmd.wr_pad80) w_wbyte = 8'h80;
        if (i_cmd.wr_zero)  w_wbyte = 8'h00;
        if (i_cmd.wr_len)   w_wbyte = r_total[{~w_lsel, 3'd0} +: 8];
    end

    // schedule word for the next round, registered during the current round
    assign w_w2  = r_w[15];
    assign w_w15 = r_w[2];
    assign w_s1  = sha256_pkg::rotr(w_w2, 17) ^ sha256_pkg::rotr(w_w2, 19) ^ (w_w2 >> 10);
    assign w_s0  = sha256_pkg::rotr(w_w15, 7) ^ sha256_pkg::rotr(w_w15, 18) ^ (w_w15 >> 3);
    always_comb begin
        if (r_round < 6'd16)
            w_sched = r_buf[r_round[3:0]];
        else
            w_sched = r_wnext;
    end

    // round function
    assign w_e   = r_v[4];
    assign w_a   = r_v[0];
    assign w_ch  = (w_e & r_v[5]) ^ (~w_e & r_v[6]);
    assign w_maj = (w_a & r_v[1]) ^ (w_a & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign w_t1  = r_v[7] + (sha256_pkg::rotr(w_e, 6) ^ sha256_pkg::rotr(w_e, 11)
                   ^ sha256_pkg::rotr(w_e, 25)) + w_ch + sha256_pkg::ROUND_K[r_round] + w_sched;
    assign w_t2  = (sha256_pkg::rotr(w_a, 2) ^ sha256_pkg::rotr(w_a, 13)
                   ^ sha256_pkg::rotr(w_a, 22)) + w_maj;

    // buffer and schedule window: payload only
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_byte || i_cmd.wr_pad80 || i_cmd.wr_zero || i_cmd.wr_len) begin
            r_buf[r_fill[5:2]][{~r_fill[1:0], 3'd0} +: 8] <= w_wbyte;
        end
        if (i_cmd.latch_total) r_total <= w_tot;
        if (i_cmd.round_en) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_sched;
            r_wnext <= w_s1 + r_w[10] + w_s0 + r_w[1];
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= w_e;
            r_v[4] <= r_v[3] + w_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= w_a;
            r_v[0] <= w_t1 + w_t2;
        end else if (i_cmd.comp_start) begin
            r_v <= r_h;
        end
    end

    // control-state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h     <= sha256_pkg::H_INIT;
            r_fill  <= 6'd0;
            r_round <= 6'd0;
            r_bits  <= 64'd0;
        end else begin
            if (i_cmd.ptr_inc) r_fill <= r_fill + 6'd1;
            if (i_cmd.round_en) r_round <= r_round + 6'd1;
            if (i_cmd.add_block) r_bits <= r_bits + 64'd512;
            if (i_cmd.comp_done) begin
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
            end
            if (i_cmd.restart) begin
                r_h    <= sha256_pkg::H_INIT;
                r_fill <= 6'd0;
                r_bits <= 64'd0;
            end
        end
    end

    assign o_stat.fill  = r_fill;
    assign o_stat.round = r_round;
    assign o_digest     = r_h[i_out_idx];

    `include "sha256_stream_hasher_assert.svh"
    `SHA_ASSERT_NEXT(a_round_step, i_cmd.round_en, r_round == $past(r_round) + 6'd1, "round step")
    `SHA_ASSERT_IMP(a_no_fill_in_round, i_cmd.round_en, !i_cmd.ptr_inc, "fill during rounds")
    `SHA_ASSERT_NEXT(a_restart_clr, i_cmd.restart, r_fill == 6'd0 && r_bits == 64'd0, "restart")

endmodule

[rtl/core/sha256_stream_hasher.sv]
// An absorb stores one byte; every 64th byte starts a compression (64 rounds + fold)
// and no input is accepted until it ends. A finish with n bytes waiting pads with
// 0x80, zeros to byte 56 and the bit length, compressing one block, or two when
// n >= 56, then 8 digest transactions, one per accepted cycle. Input waits meanwhile.
// Reset: synchronous active-low i_rst_n; hash returns to the initial values,
// counters clear; the buffer and schedule window hold no reset.
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// Byte-stream SHA-256 hasher with eight-word digest output.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, zero pad
    output logic        m_axis_tlast    // last_word
);

    sha256_pkg::t_cmd  w_cmd;
    sha256_pkg::t_stat w_stat;
    logic [2:0]        w_idx;
    logic [31:0]       w_digest;

    sha256_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_op     (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_idx   (w_idx),
        .o_cmd       (w_cmd)
    );

    sha256_dpath u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte    (s_axis_tdata),
        .i_out_idx (w_idx),
        .i_cmd     (w_cmd),
        .o_stat    (w_stat),
        .o_digest  (w_digest)
    );

    assign m_axis_tdata = {5'd0, w_idx, w_digest};
    assign m_axis_tlast = (w_idx == 3'd7);

endmodule

[dv/tb_sha256_stream_hasher.sv]
// ----------------------------------------------------------------------------
// tb_sha256_stream_hasher
// Drives byte messages and finish commands into the hasher, predicts each
// digest with a behavioral SHA-256 and checks every digest word transaction.
// ----------------------------------------------------------------------------
module tb_sha256_stream_hasher;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } t_digest_beat;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic        s_axis_tuser;   // [0] operation
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // [31:0] digest_word, [34:32] word_index, zero pad
    logic        m_axis_tlast;   // last_word

    sha256_stream_hasher dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // model state
    logic [31:0]  hash_st [8];
    logic [7:0]   blk_buf [64];
    logic [5:0]   fill_cnt;
    logic [63:0]  msg_bits;
    t_digest_beat digest_q [$];

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    bit          failed;
    int unsigned cycle_cnt;

    function automatic logic [31:0] ror32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // one 64-round compression of blk_buf into hash_st
    task automatic sha_compress();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        for (int r = 0; r < 64; r++) begin
            if (r < 16) begin
                w[r] = {blk_buf[4*r], blk_buf[4*r+1], blk_buf[4*r+2], blk_buf[4*r+3]};
            end else begin
                s1 = ror32(w[r-2], 17) ^ ror32(w[r-2], 19) ^ (w[r-2] >> 10);
                s0 = ror32(w[r-15], 7) ^ ror32(w[r-15], 18) ^ (w[r-15] >> 3);
                w[r] = s1 + w[r-7] + s0 + w[r-16];
            end
        end
        {a, b, c, d, e, f, g, h} = {hash_st[0], hash_st[1], hash_st[2], hash_st[3],
                                    hash_st[4], hash_st[5], hash_st[6], hash_st[7]};
        for (int r = 0; r < 64; r++) begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
                 + sha256_pkg::ROUND_K[r] + w[r];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
        end
        hash_st[0] += a; hash_st[1] += b; hash_st[2] += c; hash_st[3] += d;
        hash_st[4] += e; hash_st[5] += f; hash_st[6] += g; hash_st[7] += h;
    endtask

    task automatic restart_hash();
        for (int i = 0; i < 8; i++) hash_st[i] = sha256_pkg::H_INIT[i];
        fill_cnt = '0;
        msg_bits = '0;
    endtask

    // advance the model by one accepted input transaction
    task automatic predict_digest(logic op, logic [7:0] data);
        logic [63:0] total;
        int unsigned n;
        t_digest_beat beat;
        if (op == sha256_pkg::OP_ABSORB) begin
            blk_buf[fill_cnt] = data;
            fill_cnt++;
            if (fill_cnt == 0) begin
                sha_compress();
                msg_bits += 64'd512;
            end
        end else begin
            n = fill_cnt;
            total = msg_bits + 64'(n * 8);
            blk_buf[n] = 8'h80;
            for (int i = n + 1; i < 64; i++) blk_buf[i] = 8'h00;
            if (n >= 56) begin
                sha_compress();
                for (int i = 0; i < 56; i++) blk_buf[i] = 8'h00;
            end
            for (int i = 0; i < 8; i++) blk_buf[56+i] = total[63-8*i -: 8];
            sha_compress();
            for (int i = 0; i < 8; i++) begin
                beat.word = hash_st[i];
                beat.idx  = 3'(i);
                beat.last = (i == 7);
                digest_q.push_back(beat);
            end
            restart_hash();
        end
    endtask

    // clock and cycle limit
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver backpressure
    always @(negedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 1'b0;
        else m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // digest word checker
    always @(posedge i_clk) begin
        t_digest_beat exp_beat;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (digest_q.size() == 0) begin
                $error("unexpected digest word transaction %h", m_axis_tdata[31:0]);
                failed = 1'b1;
            end else begin
                exp_beat = digest_q.pop_front();
                if (m_axis_tdata[31:0] !== exp_beat.word) begin
                    $error("digest_word exp %h got %h", exp_beat.word, m_axis_tdata[31:0]);
                    failed = 1'b1;
                end
                if (m_axis_tdata[34:32] !== exp_beat.idx) begin
                    $error("word_index exp %0d got %0d", exp_beat.idx, m_axis_tdata[34:32]);
                    failed = 1'b1;
                end
                if (m_axis_tlast !== exp_beat.last) begin
                    $error("last_word exp %0b got %0b", exp_beat.last, m_axis_tlast);
                    failed = 1'b1;
                end
            end
        end
    end

    // one input transaction, with random leading idle cycles
    task automatic send_item(logic op, logic [7:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= data;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_digest(op, data);
        @(negedge i_clk);
    endtask

    task automatic go_idle();
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain_digests();
        go_idle();
        while (digest_q.size() != 0) @(negedge i_clk);
    endtask

    // empty message, byte extremes, and padding at 55/56/63/64 byte boundaries
    task automatic test_directed();
        int lens [6] = '{0, 1, 55, 56, 63, 64};
        send_item(sha256_pkg::OP_FINISH, 8'hFF);
        send_item(sha256_pkg::OP_ABSORB, 8'h00);
        send_item(sha256_pkg::OP_ABSORB, 8'hFF);
        send_item(sha256_pkg::OP_FINISH, 8'hA5);
        foreach (lens[k]) begin
            for (int i = 0; i < lens[k]; i++) send_item(sha256_pkg::OP_ABSORB, 8'($urandom));
            send_item(sha256_pkg::OP_FINISH, 8'($urandom));
        end
    endtask

    // random-length messages, mostly short, some across two or three blocks
    task automatic test_random_messages(int unsigned n_items);
        int unsigned sent = 0;
        int unsigned len;
        while (sent < n_items) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(130) : $urandom_range(20);
            for (int i = 0; i < len; i++) send_item(sha256_pkg::OP_ABSORB, 8'($urandom));
            send_item(sha256_pkg::OP_FINISH, 8'($urandom));
            sent += len + 1;
        end
    endtask

    // sender holds off until all digest words are out, then continues
    task automatic test_drain_pause();
        for (int i = 0; i < 10; i++) send_item(sha256_pkg::OP_ABSORB, 8'($urandom));
        send_item(sha256_pkg::OP_FINISH, 8'h00);
        drain_digests();
        send_item(sha256_pkg::OP_FINISH, 8'h00);
    endtask

    initial begin
        failed        = 1'b0;
        cycle_cnt     = 0;
        send_idle_pct = 17;
        recv_idle_pct = 52;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = sha256_pkg::OP_ABSORB;
        m_axis_tready = 1'b0;
        restart_hash();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random_messages(65);
        test_drain_pause();
        send_idle_pct = 52;
        recv_idle_pct = 17;
        test_random_messages(65);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_messages(65);

        drain_digests();
        repeat (200) @(negedge i_clk);
        if (!failed && digest_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

[sim.f]
+incdir+rtl/core
rtl/core/sha256_pkg.sv
rtl/core/sha256_ctrl.sv
rtl/core/sha256_dpath.sv
rtl/core/sha256_stream_hasher.sv
dv/tb_sha256_stream_hasher.sv
